// ===== rtl/acl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_pkg: shared types, constants and keyword table of the command line parser
// Character codes, word classification, result layout and command lookup.
// ----------------------------------------------------------------------------
package acl_pkg;

  localparam int ARG_SLOTS  = 4;
  localparam int OUT_ARGS   = 4;
  localparam int KW_MAX     = 6;
  localparam int KW_W       = 8 * KW_MAX;
  localparam int KW_LEN_W   = $clog2(KW_MAX + 1);
  localparam int KW_COUNT   = 11;
  localparam int CNT_W      = $clog2(ARG_SLOTS + 1);
  localparam int IDX_W      = (ARG_SLOTS > 1) ? $clog2(ARG_SLOTS) : 1;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam int APB_ADDR_W = 3;
  localparam logic REG_LINK_TIMEOUT = 1'b0;  // register index, paddr bit 2
  localparam logic [15:0] LINK_TIMEOUT_RST = 16'd500;

  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic {
    KIND_LINE = 1'b0,
    KIND_TICK = 1'b1
  } kind_e;

  typedef enum logic [3:0] {
    CMD_UNKNOWN = 4'd0,
    CMD_PING    = 4'd1,
    CMD_SAVE    = 4'd2,
    CMD_H       = 4'd3,
    CMD_MODE    = 4'd4,
    CMD_ANG     = 4'd5,
    CMD_MIX     = 4'd6,
    CMD_TRIM    = 4'd7,
    CMD_SCALE   = 4'd8,
    CMD_DIR     = 4'd9,
    CMD_ZERO    = 4'd10,
    CMD_RSTCAL  = 4'd11
  } cmd_e;

  // Classified input word, as handed from the front end to the back end.
  typedef struct packed {
    logic       tick;
    logic       term;
    logic       trim;
    logic       ws;
    logic       digit;
    logic [3:0] digit_val;
    logic       sign;
    logic       minus;
    logic       comma;
    logic [7:0] ch;
  } cls_t;

  typedef struct packed {
    kind_e                      kind;
    cmd_e                       command;
    logic [2:0]                 arg_count;
    logic [OUT_ARGS-1:0][31:0]  args;
    logic                       args_enough;
    logic                       marks_dirty;
    logic                       link_up;
    logic                       force_idle;
  } res_t;

  // Keyword names, first character in the low byte, zero padded.
  localparam logic [KW_COUNT-1:0][KW_W-1:0] KW_CHARS = {
    48'h4C41_4354_5352,  // RSTCAL
    48'h0000_4F52_455A,  // ZERO
    48'h0000_0052_4944,  // DIR
    48'h0045_4C41_4353,  // SCALE
    48'h0000_4D49_5254,  // TRIM
    48'h0000_0058_494D,  // MIX
    48'h0000_0047_4E41,  // ANG
    48'h0000_4544_4F4D,  // MODE
    48'h0000_0000_0048,  // H
    48'h0000_4556_4153,  // SAVE
    48'h0000_474E_4950   // PING
  };

  localparam logic [KW_COUNT-1:0][KW_LEN_W-1:0] KW_LEN = {
    3'd6, 3'd4, 3'd3, 3'd5, 3'd4, 3'd3, 3'd3, 3'd4, 3'd1, 3'd4, 3'd4
  };

  function automatic cmd_e kw_match(input logic [KW_W-1:0] chars,
                                    input logic [KW_LEN_W-1:0] len);
    cmd_e cmd;
    cmd = CMD_UNKNOWN;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (chars == KW_CHARS[k] && len == KW_LEN[k]) begin
        cmd = cmd_e'(4'(k + 1));
      end
    end
    return cmd;
  endfunction

  function automatic logic [2:0] min_args(input cmd_e cmd);
    logic [2:0] n;
    case (cmd)
      CMD_MODE:   n = 3'd1;
      CMD_ANG:    n = 3'd2;
      CMD_MIX:    n = 3'd3;
      CMD_TRIM:   n = 3'd2;
      CMD_SCALE:  n = 3'd2;
      CMD_DIR:    n = 3'd1;
      CMD_ZERO:   n = 3'd1;
      CMD_RSTCAL: n = 3'd1;
      default:    n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic is_dirty_cmd(input cmd_e cmd);
    logic d;
    case (cmd)
      CMD_TRIM, CMD_SCALE, CMD_DIR, CMD_ZERO, CMD_RSTCAL: d = 1'b1;
      default: d = 1'b0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/acl_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_front: input stage of the command line parser
// Accepts words, classifies the character and registers the result.
// ----------------------------------------------------------------------------
module acl_front
  import acl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] rx_byte_i,
  output      logic       push_valid_o,
  input  wire logic       push_ready_i,
  output      cls_t       push_data_o
);

  logic stg_valid_d, stg_valid_q;
  cls_t stg_d, stg_q;
  logic accept;
  logic is_digit;

  assign in_ready_o = !stg_valid_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_digit   = (rx_byte_i >= CH_ZERO) && (rx_byte_i <= CH_NINE);

  always_comb begin
    stg_d           = '0;
    stg_d.tick      = (op_e'(op_i) == OP_TICK);
    stg_d.ch        = rx_byte_i;
    stg_d.term      = (rx_byte_i == CH_LF) || (rx_byte_i == CH_NUL);
    stg_d.trim      = (rx_byte_i == CH_SPACE) || (rx_byte_i == CH_CR);
    stg_d.ws        = (rx_byte_i == CH_SPACE) || (rx_byte_i == CH_TAB) ||
                      (rx_byte_i == CH_VT) || (rx_byte_i == CH_FF) ||
                      (rx_byte_i == CH_CR);
    stg_d.digit     = is_digit;
    stg_d.digit_val = 4'(rx_byte_i - CH_ZERO);
    stg_d.sign      = (rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS);
    stg_d.minus     = (rx_byte_i == CH_MINUS);
    stg_d.comma     = (rx_byte_i == CH_COMMA);
  end

  assign stg_valid_d  = accept || (stg_valid_q && !push_ready_i);
  assign push_valid_o = stg_valid_q;
  assign push_data_o  = stg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/acl_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_fifo: short queue between the parser front end and back end
// Register based first-in first-out buffer of classified words.
// ----------------------------------------------------------------------------
module acl_fifo
  import acl_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output      logic push_ready_o,
  input  wire cls_t push_data_i,
  output      logic pop_valid_o,
  input  wire logic pop_ready_i,
  output      cls_t pop_data_o
);

  cls_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_d, cnt_q;
  logic                  push, pop;

  assign push_ready_o = (cnt_q != FIFO_CNT_W'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/acl_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// acl_back: parser and link watchdog back end
// Updates the line state one word per cycle unless stalled; registers results.
// ----------------------------------------------------------------------------
module acl_back
  import acl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [15:0] link_timeout_i,
  input  wire logic        item_valid_i,
  output      logic        item_ready_o,
  input  wire cls_t        item_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      res_t        out_o
);

  logic [KW_W-1:0]     kw_chars_d, kw_chars_q;
  logic [KW_LEN_W-1:0] kw_len_d, kw_len_q;
  logic                kw_over_d, kw_over_q;
  logic                trim_pend_d, trim_pend_q;
  logic                in_args_d, in_args_q;
  logic                stopped_d, stopped_q;
  logic [CNT_W-1:0]    arg_idx_d, arg_idx_q;
  logic                neg_d, neg_q;
  logic                sign_d, sign_q;
  logic                digit_d, digit_q;
  logic [31:0]         mag_d, mag_q;
  logic [31:0]         arg_val_q [ARG_SLOTS];
  logic                nonempty_d, nonempty_q;
  logic [31:0]         elapsed_d, elapsed_q;
  logic                out_valid_d, out_valid_q;
  res_t                out_d, out_q;

  logic                pop, produce;
  logic                slot_free, slot_wr;
  logic [CNT_W-1:0]    idx_next;
  logic [35:0]         acc;
  logic [31:0]         acc_sat, fin_val, elapsed_inc;
  logic                tick_up;
  logic                term_finish;
  logic [CNT_W-1:0]    line_cnt;
  cmd_e                line_cmd;
  logic                line_enough;
  logic [OUT_ARGS-1:0][31:0] line_args;
  res_t                line_res, tick_res;

  assign pop          = item_valid_i && (!out_valid_q || out_ready_i);
  assign item_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o  = out_valid_q;
  assign out_o        = out_q;

  assign slot_free = (arg_idx_q < CNT_W'(ARG_SLOTS));
  assign idx_next  = arg_idx_q + 1'b1;

  // Decimal accumulation: times ten plus the new digit, capped at 2^31.
  assign acc     = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1) + {32'b0, item_i.digit_val};
  assign acc_sat = (acc > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : acc[31:0];
  assign fin_val = neg_q ? (32'd0 - mag_q) : ((mag_q > POS_MAX) ? POS_MAX : mag_q);

  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign tick_up     = (elapsed_inc <= {16'b0, link_timeout_i});

  // A number still open at the end of the line counts if it has digits.
  assign term_finish = in_args_q && !stopped_q && digit_q && slot_free;
  assign line_cnt    = term_finish ? idx_next : arg_idx_q;
  assign line_cmd    = kw_over_q ? CMD_UNKNOWN : kw_match(kw_chars_q, kw_len_q);
  assign line_enough = (line_cmd != CMD_UNKNOWN) &&
                       (32'(line_cnt) >= 32'(min_args(line_cmd)));

  for (genvar g = 0; g < OUT_ARGS; g++) begin : g_args
    if (g < ARG_SLOTS) begin : g_slot
      assign line_args[g] = (32'(g) >= 32'(line_cnt)) ? 32'd0 :
                            (term_finish && 32'(g) == 32'(arg_idx_q)) ? fin_val :
                            arg_val_q[g];
    end else begin : g_none
      assign line_args[g] = 32'd0;
    end
  end

  always_comb begin
    line_res             = '0;
    line_res.kind        = KIND_LINE;
    line_res.command     = line_cmd;
    line_res.arg_count   = (32'(line_cnt) > 32'd7) ? 3'd7 : 3'(line_cnt);
    line_res.args        = line_args;
    line_res.args_enough = line_enough;
    line_res.marks_dirty = line_enough && is_dirty_cmd(line_cmd);
    line_res.link_up     = 1'b1;
    line_res.force_idle  = 1'b0;

    tick_res             = '0;
    tick_res.kind        = KIND_TICK;
    tick_res.command     = CMD_UNKNOWN;
    tick_res.link_up     = tick_up;
    tick_res.force_idle  = !tick_up;
  end

  always_comb begin
    kw_chars_d  = kw_chars_q;
    kw_len_d    = kw_len_q;
    kw_over_d   = kw_over_q;
    trim_pend_d = trim_pend_q;
    in_args_d   = in_args_q;
    stopped_d   = stopped_q;
    arg_idx_d   = arg_idx_q;
    neg_d       = neg_q;
    sign_d      = sign_q;
    digit_d     = digit_q;
    mag_d       = mag_q;
    nonempty_d  = nonempty_q;
    elapsed_d   = elapsed_q;
    slot_wr     = 1'b0;
    produce     = 1'b0;
    out_d       = out_q;

    if (pop) begin
      if (item_i.tick) begin
        elapsed_d = elapsed_inc;
        produce   = 1'b1;
        out_d     = tick_res;
      end else if (item_i.term) begin
        if (nonempty_q) begin
          produce   = 1'b1;
          out_d     = line_res;
          elapsed_d = '0;
        end
        kw_chars_d  = '0;
        kw_len_d    = '0;
        kw_over_d   = 1'b0;
        trim_pend_d = 1'b0;
        in_args_d   = 1'b0;
        stopped_d   = 1'b0;
        arg_idx_d   = '0;
        neg_d       = 1'b0;
        sign_d      = 1'b0;
        digit_d     = 1'b0;
        mag_d       = '0;
        nonempty_d  = 1'b0;
      end else begin
        if (!item_i.trim) begin
          nonempty_d = 1'b1;
        end
        if (!in_args_q) begin
          if (item_i.trim) begin
            trim_pend_d = 1'b1;
          end else begin
            // A space or CR followed by more text spoils the keyword.
            if (trim_pend_q) begin
              kw_over_d   = 1'b1;
              trim_pend_d = 1'b0;
            end
            if (item_i.comma) begin
              in_args_d = 1'b1;
            end else if (kw_len_q < KW_LEN_W'(KW_MAX)) begin
              kw_chars_d = kw_chars_q | ({{(KW_W-8){1'b0}}, item_i.ch} << {kw_len_q, 3'b000});
              kw_len_d   = kw_len_q + 1'b1;
            end else begin
              kw_over_d = 1'b1;
            end
          end
        end else if (!stopped_q) begin
          if (!digit_q) begin
            if (item_i.digit) begin
              digit_d = 1'b1;
              mag_d   = {28'b0, item_i.digit_val};
            end else if (!sign_q && item_i.ws) begin
              // Leading whitespace is skipped.
            end else if (!sign_q && item_i.sign) begin
              sign_d = 1'b1;
              neg_d  = item_i.minus;
            end else begin
              stopped_d = 1'b1;
            end
          end else if (item_i.digit) begin
            mag_d = acc_sat;
          end else begin
            if (slot_free) begin
              slot_wr   = 1'b1;
              arg_idx_d = idx_next;
            end
            neg_d   = 1'b0;
            sign_d  = 1'b0;
            digit_d = 1'b0;
            if (!item_i.comma || (arg_idx_d >= CNT_W'(ARG_SLOTS))) begin
              stopped_d = 1'b1;
            end
          end
        end
      end
    end

    out_valid_d = pop ? produce : (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_chars_q  <= '0;
      kw_len_q    <= '0;
      kw_over_q   <= 1'b0;
      trim_pend_q <= 1'b0;
      in_args_q   <= 1'b0;
      stopped_q   <= 1'b0;
      arg_idx_q   <= '0;
      neg_q       <= 1'b0;
      sign_q      <= 1'b0;
      digit_q     <= 1'b0;
      mag_q       <= '0;
      nonempty_q  <= 1'b0;
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      kw_chars_q  <= kw_chars_d;
      kw_len_q    <= kw_len_d;
      kw_over_q   <= kw_over_d;
      trim_pend_q <= trim_pend_d;
      in_args_q   <= in_args_d;
      stopped_q   <= stopped_d;
      arg_idx_q   <= arg_idx_d;
      neg_q       <= neg_d;
      sign_q      <= sign_d;
      digit_q     <= digit_d;
      mag_q       <= mag_d;
      nonempty_q  <= nonempty_d;
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (slot_wr) begin
      arg_val_q[arg_idx_q[IDX_W-1:0]] <= fin_val;
    end
  end

`ifndef NO_ASSERTIONS
  a_line_link_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_LINE |-> out_q.link_up && !out_q.force_idle)
    else $error("line result does not report the link up");

  a_tick_fields : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.kind == KIND_TICK |->
      out_q.link_up != out_q.force_idle && out_q.command == CMD_UNKNOWN &&
      out_q.arg_count == 3'd0)
    else $error("tick result carries inconsistent fields");

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    arg_idx_q <= CNT_W'(ARG_SLOTS))
    else $error("argument index beyond the slot count");

  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && item_i.tick |=> out_valid_q && out_q.kind == KIND_TICK)
    else $error("tick word did not produce a link status result");
`endif

endmodule
`default_nettype wire

// ===== rtl/ascii_command_line_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ascii_command_line_parser: ASCII command line parser with link watchdog
// Parses received characters into command lines and reports link status.
// ----------------------------------------------------------------------------
// The block takes one word per clock on its input channel, a received
// character or a millisecond tick, and keeps that rate indefinitely as long as
// the result side keeps up. A tick always returns a link status word; a line
// terminator (LF or NUL) returns one parsed command word unless the trimmed
// line was empty; other characters return nothing. A word passes a
// classification register, a two-entry queue and the parser back end, whose
// result register holds the result until it is read. The rate is set by the
// back end, which updates the whole line state per word, its longest path
// being the times-ten decimal accumulation. The link timeout register sits at
// byte address 0 of the configuration port; the user must write it only while
// the block is idle, which the block itself does not enforce.
module ascii_command_line_parser
  import acl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output      logic                  in_ready_o,
  input  wire logic                  op_i,
  input  wire logic [7:0]            rx_byte_i,
  output      logic                  out_valid_o,
  input  wire logic                  out_ready_i,
  output      logic                  kind_o,
  output      logic [3:0]            command_o,
  output      logic [2:0]            arg_count_o,
  output      logic signed [31:0]    arg_first_o,
  output      logic signed [31:0]    arg_second_o,
  output      logic signed [31:0]    arg_third_o,
  output      logic signed [31:0]    arg_fourth_o,
  output      logic                  args_enough_o,
  output      logic                  marks_dirty_o,
  output      logic                  link_up_o,
  output      logic                  force_idle_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  logic [15:0] link_timeout_q;
  logic        cfg_wr;
  logic        push_valid, push_ready;
  cls_t        push_data;
  logic        item_valid, item_ready;
  cls_t        item;
  res_t        res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_LINK_TIMEOUT);
  assign prdata = (paddr[2] == REG_LINK_TIMEOUT) ? {16'b0, link_timeout_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_timeout_q <= LINK_TIMEOUT_RST;
    end else if (cfg_wr) begin
      link_timeout_q <= pwdata[15:0];
    end
  end

  acl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  acl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (item_valid),
    .pop_ready_i  (item_ready),
    .pop_data_o   (item)
  );

  acl_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .link_timeout_i (link_timeout_q),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_o          (res)
  );

  assign kind_o        = res.kind;
  assign command_o     = res.command;
  assign arg_count_o   = res.arg_count;
  assign arg_first_o   = $signed(res.args[0]);
  assign arg_second_o  = $signed(res.args[1]);
  assign arg_third_o   = $signed(res.args[2]);
  assign arg_fourth_o  = $signed(res.args[3]);
  assign args_enough_o = res.args_enough;
  assign marks_dirty_o = res.marks_dirty;
  assign link_up_o     = res.link_up;
  assign force_idle_o  = res.force_idle;

endmodule
`default_nettype wire

// ===== tb/sv/ascii_command_line_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_command_line_parser_tb: self-checking testbench of the line parser
// Feeds received bytes and millisecond ticks through the input channel, keeps
// its own model of the line parser and the link watchdog, and compares every
// result word field by field with the oldest predicted one. A short scripted
// part is followed by random lines under several link timeouts and idling
// profiles on both channels.
// ----------------------------------------------------------------------------
module ascii_command_line_parser_tb;
  import acl_pkg::*;

  typedef struct packed {
    kind_e           kind;
    cmd_e            command;
    logic [2:0]      arg_count;
    logic [3:0][31:0] args;
    logic            args_enough;
    logic            marks_dirty;
    logic            link_up;
    logic            force_idle;
  } report_t;

  typedef struct {
    bit         tick;
    string      text;
    logic [7:0] ender;
    bit         typed;
    report_t    want;
  } script_row_t;

  localparam logic [APB_ADDR_W-1:0] TIMEOUT_ADDR = {REG_LINK_TIMEOUT, 2'b00};

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic                  op_i = 1'b0;
  logic [7:0]            rx_byte_i = 8'h00;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic                  kind_o;
  logic [3:0]            command_o;
  logic [2:0]            arg_count_o;
  logic signed [31:0]    arg_first_o;
  logic signed [31:0]    arg_second_o;
  logic signed [31:0]    arg_third_o;
  logic signed [31:0]    arg_fourth_o;
  logic                  args_enough_o;
  logic                  marks_dirty_o;
  logic                  link_up_o;
  logic                  force_idle_o;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;

  ascii_command_line_parser u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .command_o    (command_o),
    .arg_count_o  (arg_count_o),
    .arg_first_o  (arg_first_o),
    .arg_second_o (arg_second_o),
    .arg_third_o  (arg_third_o),
    .arg_fourth_o (arg_fourth_o),
    .args_enough_o(args_enough_o),
    .marks_dirty_o(marks_dirty_o),
    .link_up_o    (link_up_o),
    .force_idle_o (force_idle_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("ascii_command_line_parser test failed");
    $finish;
  end

  // Command names in the order of their codes, starting at CMD_PING.
  string command_names[11] = '{"PING", "SAVE", "H", "MODE", "ANG", "MIX",
                               "TRIM", "SCALE", "DIR", "ZERO", "RSTCAL"};
  string limit_digits[5] = '{"2147483647", "2147483648", "2147483649", "0", "00"};
  logic [7:0] blanks[5] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR};

  // Parser model state.
  logic [KW_W-1:0] kw_text;
  int              kw_len;
  bit              kw_spoiled;
  bit              trim_held;
  bit              past_comma;
  bit              args_halted;
  int              args_done;
  bit              num_neg;
  bit              num_signed;
  bit              num_digits;
  logic [31:0]     slot_val[ARG_SLOTS];
  bit              line_live;
  logic [31:0]     ms_since_line = '0;
  logic [15:0]     link_limit = LINK_TIMEOUT_RST;

  report_t     awaited_reports[$];
  bit          use_typed = 1'b0;
  report_t     typed_want;
  int unsigned words_sent = 0;
  int unsigned mismatch_count = 0;
  int          send_idle_pct = 8;
  int          recv_idle_pct = 52;

  function automatic report_t typed_report(kind_e k, cmd_e c, logic [2:0] n,
                                           logic [31:0] a0, logic [31:0] a1,
                                           logic [31:0] a2, logic [31:0] a3,
                                           logic enough, logic dirty, logic up);
    report_t r;
    r = '0;
    r.kind = k;
    r.command = c;
    r.arg_count = n;
    r.args[0] = a0;
    r.args[1] = a1;
    r.args[2] = a2;
    r.args[3] = a3;
    r.args_enough = enough;
    r.marks_dirty = dirty;
    r.link_up = up;
    r.force_idle = (k == KIND_TICK) && !up;
    return r;
  endfunction

  function automatic cmd_e lookup_command(input logic [KW_W-1:0] text, input int len,
                                          input bit spoiled);
    cmd_e  found;
    string name;
    bit    same;
    found = CMD_UNKNOWN;
    if (!spoiled) begin
      for (int k = 0; k < 11; k++) begin
        name = command_names[k];
        if (name.len() == len) begin
          same = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (text[8*i +: 8] != name[i]) same = 1'b0;
          end
          if (same) found = cmd_e'(4'(k + 1));
        end
      end
    end
    return found;
  endfunction

  function automatic int needed_args(input cmd_e cmd);
    case (cmd)
      CMD_MODE, CMD_DIR, CMD_ZERO, CMD_RSTCAL: return 1;
      CMD_ANG, CMD_TRIM, CMD_SCALE:            return 2;
      CMD_MIX:                                 return 3;
      default:                                 return 0;
    endcase
  endfunction

  task automatic clear_line_state();
    kw_text = '0;
    kw_len = 0;
    kw_spoiled = 1'b0;
    trim_held = 1'b0;
    past_comma = 1'b0;
    args_halted = 1'b0;
    args_done = 0;
    num_neg = 1'b0;
    num_signed = 1'b0;
    num_digits = 1'b0;
    line_live = 1'b0;
    for (int i = 0; i < ARG_SLOTS; i++) slot_val[i] = '0;
  endtask

  // The slot in progress holds a magnitude; turn it into a saturated value.
  task automatic close_number();
    if (args_done < ARG_SLOTS) begin
      if (num_neg) begin
        slot_val[args_done] = -slot_val[args_done];
      end else if (slot_val[args_done] > POS_MAX) begin
        slot_val[args_done] = POS_MAX;
      end
      args_done++;
    end
    num_neg = 1'b0;
    num_signed = 1'b0;
    num_digits = 1'b0;
  endtask

  task automatic queue_report(input report_t rep);
    if (use_typed) begin
      awaited_reports.push_back(typed_want);
      use_typed = 1'b0;
    end else begin
      awaited_reports.push_back(rep);
    end
  endtask

  // Updates the parser model with one accepted word and queues its result, if it has one.
  task automatic interpret_word(input op_e op, input logic [7:0] ch);
    report_t     rep;
    cmd_e        cmd;
    bit          is_digit;
    logic [63:0] grown;
    rep = '0;
    is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    if (op == OP_TICK) begin
      if (ms_since_line != 32'hFFFF_FFFF) ms_since_line++;
      rep.kind = KIND_TICK;
      rep.link_up = (ms_since_line <= {16'h0000, link_limit});
      rep.force_idle = !rep.link_up;
      queue_report(rep);
    end else if (ch == CH_LF || ch == CH_NUL) begin
      if (line_live) begin
        if (past_comma && !args_halted && num_digits) close_number();
        cmd = lookup_command(kw_text, kw_len, kw_spoiled);
        rep.kind = KIND_LINE;
        rep.command = cmd;
        rep.arg_count = 3'(args_done);
        for (int i = 0; i < 4; i++) rep.args[i] = (i < args_done) ? slot_val[i] : '0;
        rep.args_enough = (cmd != CMD_UNKNOWN) && (args_done >= needed_args(cmd));
        rep.marks_dirty = rep.args_enough && (cmd >= CMD_TRIM);
        rep.link_up = 1'b1;
        ms_since_line = '0;
        queue_report(rep);
      end
      clear_line_state();
    end else begin
      if (ch != CH_SPACE && ch != CH_CR) line_live = 1'b1;
      if (!past_comma) begin
        if (ch == CH_SPACE || ch == CH_CR) begin
          trim_held = 1'b1;
        end else begin
          // A blank followed by more text means the blank was inside the keyword.
          if (trim_held) begin
            kw_spoiled = 1'b1;
            trim_held = 1'b0;
          end
          if (ch == CH_COMMA) begin
            past_comma = 1'b1;
          end else if (kw_len < KW_MAX) begin
            kw_text[8*kw_len +: 8] = ch;
            kw_len++;
          end else begin
            kw_spoiled = 1'b1;
          end
        end
      end else if (!args_halted) begin
        if (!num_digits) begin
          if (is_digit) begin
            num_digits = 1'b1;
            if (args_done < ARG_SLOTS) slot_val[args_done] = {28'h0, ch[3:0]};
          end else if (!num_signed && (ch == CH_SPACE || ch == CH_TAB || ch == CH_VT ||
                                       ch == CH_FF || ch == CH_CR)) begin
            // Leading whitespace before a number is skipped.
          end else if (!num_signed && (ch == CH_PLUS || ch == CH_MINUS)) begin
            num_signed = 1'b1;
            num_neg = (ch == CH_MINUS);
          end else begin
            args_halted = 1'b1;
          end
        end else if (is_digit) begin
          if (args_done < ARG_SLOTS) begin
            grown = {32'h0, slot_val[args_done]} * 64'd10 + {60'h0, ch[3:0]};
            if (grown > {32'h0, MAG_LIMIT}) grown = {32'h0, MAG_LIMIT};
            slot_val[args_done] = grown[31:0];
          end
        end else begin
          close_number();
          if (ch != CH_COMMA || args_done >= ARG_SLOTS) args_halted = 1'b1;
        end
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      report_mismatch($sformatf("%s expected %0h got %0h", name, want, got));
    end
  endtask

  task automatic send_word(input op_e op, input logic [7:0] ch);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    rx_byte_i <= ch;
    do @(posedge clk_i); while (!in_ready_o);
    interpret_word(op, ch);
    words_sent++;
  endtask

  // Lets all predicted results drain, then waits for words still in flight.
  task automatic wait_quiet(input int extra);
    in_valid_i <= 1'b0;
    while (awaited_reports.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic program_timeout(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= TIMEOUT_ADDR;
    pwdata <= {16'h0000, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    link_limit = value;
    // Read the register back with a second setup and access pair.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[15:0] !== value) begin
      report_mismatch($sformatf("link timeout readback expected %0h got %0h",
                                value, prdata[15:0]));
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Mostly well-formed command lines with random content, some noise and breakage.
  task automatic send_random_line();
    logic [7:0] text[$];
    string      num;
    int         r;
    int         nargs;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 12)) send_word(OP_TICK, 8'($urandom_range(0, 255)));
    end
    if (r < 8) begin
      repeat ($urandom_range(1, 12)) text.push_back(8'($urandom_range(0, 255)));
    end else if (r < 12) begin
      repeat ($urandom_range(0, 3)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_CR);
    end else begin
      if ($urandom_range(0, 99) < 88) begin
        num = command_names[$urandom_range(0, 10)];
        foreach (num[i]) text.push_back(num[i]);
      end else begin
        repeat ($urandom_range(1, 8)) text.push_back(8'($urandom_range(8'h41, 8'h5A)));
      end
      if ($urandom_range(0, 99) < 5) text.insert($urandom_range(0, text.size()), CH_SPACE);
      nargs = $urandom_range(0, 5);
      if (nargs > 0 || $urandom_range(0, 3) == 0) text.push_back(CH_COMMA);
      for (int a = 0; a < nargs; a++) begin
        if (a > 0) begin
          text.push_back(($urandom_range(0, 99) < 5) ? 8'($urandom_range(0, 255)) : CH_COMMA);
        end
        if ($urandom_range(0, 99) < 20) begin
          repeat ($urandom_range(1, 2)) text.push_back(blanks[$urandom_range(0, 4)]);
        end
        if ($urandom_range(0, 99) < 40) text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
        case ($urandom_range(0, 5))
          0: num = $sformatf("%0d", $urandom_range(0, 999));
          1: num = $sformatf("%0d", $urandom);
          2: num = limit_digits[$urandom_range(0, 4)];
          3: begin
            num = "";
            repeat ($urandom_range(10, 14)) num = {num, $sformatf("%0d", $urandom_range(0, 9))};
          end
          4: num = "";
          default: num = $sformatf("%0d", $urandom_range(0, 9));
        endcase
        foreach (num[i]) text.push_back(num[i]);
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 2)) text.push_back($urandom_range(0, 1) ? CH_SPACE : CH_CR);
      end
    end
    text.push_back(($urandom_range(0, 99) < 80) ? CH_LF : CH_NUL);
    foreach (text[i]) begin
      if ($urandom_range(0, 99) < 6) send_word(OP_TICK, 8'($urandom_range(0, 255)));
      send_word(OP_BYTE, text[i]);
    end
  endtask

  task automatic random_stretch(input int unsigned count);
    int unsigned target;
    target = words_sent + count;
    while (words_sent < target) send_random_line();
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin : check_results
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_reports.size() == 0) begin
        report_mismatch("result word with none expected");
      end else begin
        want = awaited_reports.pop_front();
        check_field("kind", 32'(want.kind), 32'(kind_o));
        check_field("command", 32'(want.command), 32'(command_o));
        check_field("arg_count", 32'(want.arg_count), 32'(arg_count_o));
        check_field("arg_first", want.args[0], arg_first_o);
        check_field("arg_second", want.args[1], arg_second_o);
        check_field("arg_third", want.args[2], arg_third_o);
        check_field("arg_fourth", want.args[3], arg_fourth_o);
        check_field("args_enough", 32'(want.args_enough), 32'(args_enough_o));
        check_field("marks_dirty", 32'(want.marks_dirty), 32'(marks_dirty_o));
        check_field("link_up", 32'(want.link_up), 32'(link_up_o));
        check_field("force_idle", 32'(want.force_idle), 32'(force_idle_o));
      end
    end
  end

  initial begin : run_test
    script_row_t script[$];
    clear_line_state();

    // Rows with a typed result can be read straight off the line; the rest
    // rely on the parser model. Empty lines expect nothing.
    script.push_back('{1'b1, "", CH_NUL, 1'b1,
        typed_report(KIND_TICK, CMD_UNKNOWN, 3'd0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1)});
    script.push_back('{1'b0, "PING", CH_LF, 1'b1,
        typed_report(KIND_LINE, CMD_PING, 3'd0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b1)});
    script.push_back('{1'b0, "RSTCAL,-2147483648", CH_LF, 1'b1,
        typed_report(KIND_LINE, CMD_RSTCAL, 3'd1, 32'h8000_0000, 0, 0, 0, 1'b1, 1'b1, 1'b1)});
    script.push_back('{1'b0, "TRIM,2147483647,99999999999", CH_NUL, 1'b1,
        typed_report(KIND_LINE, CMD_TRIM, 3'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                     1'b1, 1'b1, 1'b1)});
    script.push_back('{1'b0, "ANG,1,2,3,4,5", CH_LF, 1'b1,
        typed_report(KIND_LINE, CMD_ANG, 3'd4, 1, 2, 3, 4, 1'b1, 1'b0, 1'b1)});
    script.push_back('{1'b0, "MIX,1,2", CH_LF, 1'b1,
        typed_report(KIND_LINE, CMD_MIX, 3'd2, 1, 2, 0, 0, 1'b0, 1'b0, 1'b1)});
    script.push_back('{1'b0, "", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, " \015 ", CH_NUL, 1'b0, '0});
    script.push_back('{1'b0, "SCALE,\011\013\014\015 +5,-0", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "H ,1", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, " PING", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "MODE,-", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "MODE,+-3", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "DIR,7x,8", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "ZERO,,5", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "SAVE\015 \015", CH_NUL, 1'b0, '0});
    script.push_back('{1'b0, "SAVE,5 ,6", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "SCALEXY,1", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "\377,3", CH_LF, 1'b0, '0});
    script.push_back('{1'b0, "DIR,-0042", CH_LF, 1'b0, '0});
    script.push_back('{1'b1, "", CH_NUL, 1'b1,
        typed_report(KIND_TICK, CMD_UNKNOWN, 3'd0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b1)});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[r]) begin
      if (script[r].tick) begin
        typed_want = script[r].want;
        use_typed = script[r].typed;
        send_word(OP_TICK, 8'($urandom_range(0, 255)));
      end else begin
        foreach (script[r].text[i]) send_word(OP_BYTE, script[r].text[i]);
        typed_want = script[r].want;
        use_typed = script[r].typed;
        send_word(OP_BYTE, script[r].ender);
      end
    end

    wait_quiet(8);
    program_timeout(16'd0);
    random_stretch(70);

    wait_quiet(8);
    send_idle_pct = 52;
    recv_idle_pct = 8;
    program_timeout(16'hFFFF);
    random_stretch(70);

    wait_quiet(8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_timeout(16'd7);
    random_stretch(70);

    wait_quiet(20);
    if (mismatch_count == 0) begin
      $display("ascii_command_line_parser test passed");
    end else begin
      $display("ascii_command_line_parser test failed");
    end
    $finish;
  end

endmodule
